[rtl/mesh_face_key_generator_assert.svh]
// Assertion macros shared by the checker files of the face key generator.
// Needs clk and arst_n in the scope of use.
`ifndef MESH_FACE_KEY_GENERATOR_ASSERT_SVH
`define MESH_FACE_KEY_GENERATOR_ASSERT_SVH

// same-cycle implication
`define MFKG_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mfkg check failed");

// next-cycle implication
`define MFKG_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mfkg check failed");

`endif

[rtl/mfkg_pkg.sv]
// Types, cell shape tables and command/status structs of the face key generator.
// No dependencies.
package mfkg_pkg;

	localparam logic [7:0] CODE_EDGE = 8'd3;
	localparam logic [7:0] CODE_TRI  = 8'd5;
	localparam logic [7:0] CODE_QUAD = 8'd9;
	localparam logic [7:0] CODE_TET  = 8'd10;
	localparam logic [7:0] CODE_HEX  = 8'd12;

	typedef logic [31:0] node_t;

	typedef enum logic [2:0] {
		SH_NONE,
		SH_EDGE,
		SH_TRI,
		SH_QUAD,
		SH_TET,
		SH_HEX
	} shape_t;

	typedef struct packed {
		logic       known;
		logic [2:0] faces;
		logic [2:0] per_face;
	} shape_info_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GATHER,
		ST_SORT,
		ST_FOLD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       load;
		logic       gather;
		logic       sort;
		logic       fold;
		logic       emit;
		logic [2:0] face;
		logic [1:0] step;
		logic       last;
	} dp_cmd_t;

	typedef struct packed {
		shape_info_t info;
		logic        out_free;
	} dp_stat_t;

	// local node tables, one row of per_face entries for each face
	localparam logic [0:1][2:0] MAP_EDGE = {3'd0, 3'd1};
	localparam logic [0:5][2:0] MAP_TRI  = {3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd0};
	localparam logic [0:7][2:0] MAP_QUAD = {3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd0};
	localparam logic [0:11][2:0] MAP_TET = {3'd0, 3'd2, 3'd1, 3'd0, 3'd3, 3'd2,
		3'd0, 3'd1, 3'd3, 3'd1, 3'd2, 3'd3};
	localparam logic [0:23][2:0] MAP_HEX = {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
		3'd0, 3'd1, 3'd5, 3'd4, 3'd1, 3'd2, 3'd6, 3'd5,
		3'd2, 3'd3, 3'd7, 3'd6, 3'd3, 3'd0, 3'd4, 3'd7};

	function automatic shape_t shape_of(logic [7:0] code);
		shape_t sh;
		case (code)
			CODE_EDGE: sh = SH_EDGE;
			CODE_TRI:  sh = SH_TRI;
			CODE_QUAD: sh = SH_QUAD;
			CODE_TET:  sh = SH_TET;
			CODE_HEX:  sh = SH_HEX;
			default:   sh = SH_NONE;
		endcase
		return sh;
	endfunction

	function automatic shape_info_t info_of(shape_t sh);
		shape_info_t si;
		case (sh)
			SH_EDGE: si = '{known: 1'b1, faces: 3'd2, per_face: 3'd1};
			SH_TRI:  si = '{known: 1'b1, faces: 3'd3, per_face: 3'd2};
			SH_QUAD: si = '{known: 1'b1, faces: 3'd4, per_face: 3'd2};
			SH_TET:  si = '{known: 1'b1, faces: 3'd4, per_face: 3'd3};
			SH_HEX:  si = '{known: 1'b1, faces: 3'd6, per_face: 3'd4};
			default: si = '{known: 1'b0, faces: 3'd1, per_face: 3'd1};
		endcase
		return si;
	endfunction

	// local node number of slot k of a face
	function automatic logic [2:0] map_node(shape_t sh, logic [2:0] face, logic [1:0] k);
		logic [4:0] idx;
		logic [2:0] r;
		r   = '0;
		idx = '0;
		case (sh)
			SH_EDGE: r = MAP_EDGE[face[0]];
			SH_TRI: begin
				idx = {1'b0, face, k[0]};
				if (idx < 5'd6) r = MAP_TRI[idx[2:0]];
			end
			SH_QUAD: r = MAP_QUAD[{face[1:0], k[0]}];
			SH_TET: begin
				idx = 5'({face, 1'b0}) + 5'(face) + 5'(k);
				if (idx < 5'd12) r = MAP_TET[idx[3:0]];
			end
			SH_HEX: begin
				idx = {face, k};
				if (idx < 5'd24) r = MAP_HEX[idx];
			end
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[rtl/mfkg_ctrl.sv]
// Sequencer of the face key generator: walks faces, sort passes and fold steps.
// Depends on mfkg_pkg.
module mfkg_ctrl
	import mfkg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cell_valid,
	output logic     cell_stall,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	state_t     state_q, state_d;
	logic [2:0] face_q;
	logic [1:0] step_q;
	logic       step_end;
	logic       last;
	logic       accept;

	assign accept   = cell_valid && !cell_stall;
	assign step_end = ({1'b0, step_q} == stat.info.per_face - 3'd1);
	assign last     = !stat.info.known || (face_q == stat.info.faces - 3'd1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (cell_valid) state_d = ST_GATHER;
			ST_GATHER: begin
				if (!stat.info.known) state_d = ST_EMIT;
				else if (stat.info.per_face == 3'd1) state_d = ST_FOLD;
				else state_d = ST_SORT;
			end
			ST_SORT:   if (step_end) state_d = ST_FOLD;
			ST_FOLD:   if (step_end) state_d = ST_EMIT;
			ST_EMIT: begin
				if (stat.out_free) state_d = last ? ST_IDLE : ST_GATHER;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cell_stall = (state_q != ST_IDLE);
		cmd        = '0;
		cmd.load   = accept;
		cmd.gather = (state_q == ST_GATHER);
		cmd.sort   = (state_q == ST_SORT);
		cmd.fold   = (state_q == ST_FOLD);
		cmd.emit   = (state_q == ST_EMIT) && stat.out_free;
		cmd.face   = face_q;
		cmd.step   = step_q;
		cmd.last   = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			face_q  <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) step_q <= '0;
			else step_q <= step_q + 2'd1;
			if (accept) face_q <= '0;
			else if (cmd.emit) face_q <= face_q + 3'd1;
		end
	end

endmodule

[rtl/mfkg_dp.sv]
// Datapath of the face key generator: node store, sorter, pairing unit, output word.
// Depends on mfkg_pkg.
module mfkg_dp
	import mfkg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	output dp_stat_t   stat,
	input  logic [7:0] cell_type,
	input  node_t      node_0,
	input  node_t      node_1,
	input  node_t      node_2,
	input  node_t      node_3,
	input  node_t      node_4,
	input  node_t      node_5,
	input  node_t      node_6,
	input  node_t      node_7,
	output logic       face_valid,
	input  logic       face_stall,
	output logic [2:0] face_index,
	output node_t      face_key,
	output logic       type_known,
	output logic       last_face
);

	shape_t      sh_q;
	shape_info_t info;
	node_t       node_q [8];
	node_t       v_q [4];
	node_t       v_d [4];
	node_t       acc_q;
	node_t       pair_s, pair_p, pair_r;
	logic        face_valid_q;

	assign info          = info_of(sh_q);
	assign stat.info     = info;
	assign stat.out_free = !face_valid_q || !face_stall;
	assign face_valid    = face_valid_q;

	// one Cantor step: sum, wrapped product, halve, add
	assign pair_s = acc_q + v_q[cmd.step];
	assign pair_p = 32'((pair_s + 32'd1) * pair_s);
	assign pair_r = (pair_p >> 1) + v_q[cmd.step];

	// gather pads unused slots with all ones so they stay at the top
	always_comb begin
		for (int k = 0; k < 4; k++) v_d[k] = v_q[k];
		if (cmd.gather) begin
			for (int k = 0; k < 4; k++) begin
				if (3'(k) < info.per_face)
					v_d[k] = node_q[map_node(sh_q, cmd.face, 2'(k))];
				else
					v_d[k] = '1;
			end
		end else if (cmd.sort) begin
			if (!cmd.step[0]) begin
				if (v_q[0] > v_q[1]) begin
					v_d[0] = v_q[1];
					v_d[1] = v_q[0];
				end
				if (v_q[2] > v_q[3]) begin
					v_d[2] = v_q[3];
					v_d[3] = v_q[2];
				end
			end else if (v_q[1] > v_q[2]) begin
				v_d[1] = v_q[2];
				v_d[2] = v_q[1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sh_q      <= shape_of(cell_type);
			node_q[0] <= node_0;
			node_q[1] <= node_1;
			node_q[2] <= node_2;
			node_q[3] <= node_3;
			node_q[4] <= node_4;
			node_q[5] <= node_5;
			node_q[6] <= node_6;
			node_q[7] <= node_7;
		end
		for (int k = 0; k < 4; k++) v_q[k] <= v_d[k];
		if (cmd.fold) acc_q <= (cmd.step == 2'd0) ? v_q[0] : pair_r;
		if (cmd.emit) begin
			face_index <= info.known ? cmd.face : 3'd0;
			face_key   <= info.known ? acc_q : '0;
			type_known <= info.known;
			last_face  <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) face_valid_q <= 1'b1;
			else if (!face_stall) face_valid_q <= 1'b0;
		end
	end

endmodule

[rtl/mesh_face_key_generator.sv]
// Cell in, face keys out. Per face: gather, sort passes (none when the face has one node),
// fold steps, then emit, which waits while the output word is still held; the cell accept
// comes first. An unknown type gathers and emits once. One cell at a time; the fold runs
// on the single pairing multiplier, one step a cycle.
// arst_n clears the sequencer and the output valid; data registers hold no reset.
module mesh_face_key_generator
	import mfkg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// cell word
	input  logic        cell_valid,
	output logic        cell_stall,
	input  logic [7:0]  cell_type,
	input  logic [31:0] node_0,
	input  logic [31:0] node_1,
	input  logic [31:0] node_2,
	input  logic [31:0] node_3,
	input  logic [31:0] node_4,
	input  logic [31:0] node_5,
	input  logic [31:0] node_6,
	input  logic [31:0] node_7,
	// face word
	output logic        face_valid,
	input  logic        face_stall,
	output logic [2:0]  face_index,
	output logic [31:0] face_key,
	output logic        type_known,
	output logic        last_face
);

	// The sequencer stalls the cell side from the accept until the last face
	// word has gone into the output register. That register lets the next cell
	// word in while the final face word still waits downstream.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	mfkg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.cmd        (cmd),
		.stat       (stat)
	);

	// Datapath: cell store, four-slot odd-even transposition sorter, one
	// Cantor pairing step per cycle, registered face word.
	mfkg_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cell_type  (cell_type),
		.node_0     (node_0),
		.node_1     (node_1),
		.node_2     (node_2),
		.node_3     (node_3),
		.node_4     (node_4),
		.node_5     (node_5),
		.node_6     (node_6),
		.node_7     (node_7),
		.face_valid (face_valid),
		.face_stall (face_stall),
		.face_index (face_index),
		.face_key   (face_key),
		.type_known (type_known),
		.last_face  (last_face)
	);

endmodule

[rtl/mfkg_chk.sv]
// Port-level checks of the face key generator, bound to the top level.
// Depends on mesh_face_key_generator_assert.svh.
`include "mesh_face_key_generator_assert.svh"

module mfkg_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        cell_valid,
	input logic        cell_stall,
	input logic        face_valid,
	input logic        face_stall,
	input logic [2:0]  face_index,
	input logic [31:0] face_key,
	input logic        type_known,
	input logic        last_face
);

	// stalled face word holds
	`MFKG_ASSERT_NXT(a_face_hold, face_valid && face_stall, face_valid && $stable({face_index, face_key, type_known, last_face}))
	// a cell in work blocks the next one
	`MFKG_ASSERT_NXT(a_busy_after_accept, cell_valid && !cell_stall, cell_stall)
	// unknown type: single zero word that closes the cell
	`MFKG_ASSERT_IMP(a_unknown_word, face_valid && !type_known, last_face && face_index == 3'd0 && face_key == 32'd0)
	// no more than six faces
	`MFKG_ASSERT_IMP(a_face_range, face_valid, face_index <= 3'd5)

endmodule

bind mesh_face_key_generator mfkg_chk u_chk (.*);

[test/mesh_face_key_generator_checker.sv]
// Face word checker for the mesh face key generator: predicts the key of every face of each
// accepted cell word and compares the face words that leave the block, in order.
// Depends on mfkg_pkg for the cell type codes.
module mfkg_face_checker
	import mfkg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cell_valid,
	input  logic        cell_stall,
	input  logic [7:0]  cell_type,
	input  logic [31:0] node_0,
	input  logic [31:0] node_1,
	input  logic [31:0] node_2,
	input  logic [31:0] node_3,
	input  logic [31:0] node_4,
	input  logic [31:0] node_5,
	input  logic [31:0] node_6,
	input  logic [31:0] node_7,
	input  logic        face_valid,
	input  logic        face_stall,
	input  logic [2:0]  face_index,
	input  logic [31:0] face_key,
	input  logic        type_known,
	input  logic        last_face,
	output int          fail_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]  index;
		logic [31:0] key;
		logic        known;
		logic        last;
	} face_word_t;

	// local node of each face slot, faces laid out row by row
	localparam logic [0:1][2:0]  EDGE_LOCAL = {3'd0, 3'd1};
	localparam logic [0:5][2:0]  TRI_LOCAL  = {3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd0};
	localparam logic [0:7][2:0]  QUAD_LOCAL = {3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd0};
	localparam logic [0:11][2:0] TET_LOCAL  = {3'd0, 3'd2, 3'd1, 3'd0, 3'd3, 3'd2,
		3'd0, 3'd1, 3'd3, 3'd1, 3'd2, 3'd3};
	localparam logic [0:23][2:0] HEX_LOCAL  = {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
		3'd0, 3'd1, 3'd5, 3'd4, 3'd1, 3'd2, 3'd6, 3'd5,
		3'd2, 3'd3, 3'd7, 3'd6, 3'd3, 3'd0, 3'd4, 3'd7};

	face_word_t expected_faces[$];
	int         errors;

	// one Cantor pairing step, every operation wrapping at 32 bits
	function automatic logic [31:0] cantor_step(logic [31:0] a, logic [31:0] b);
		logic [31:0] s;
		logic [31:0] p;
		s = a + b;
		p = (s + 32'd1) * s;
		return (p >> 1) + b;
	endfunction

	function automatic logic [2:0] face_slot_node(logic [7:0] code, int at);
		logic [2:0] r;
		r = '0;
		case (code)
			CODE_EDGE: r = EDGE_LOCAL[at];
			CODE_TRI:  r = TRI_LOCAL[at];
			CODE_QUAD: r = QUAD_LOCAL[at];
			CODE_TET:  r = TET_LOCAL[at];
			CODE_HEX:  r = HEX_LOCAL[at];
			default:   r = '0;
		endcase
		return r;
	endfunction

	task automatic predict_faces(logic [7:0] code, logic [7:0][31:0] nodes);
		int          faces;
		int          per_face;
		int          j;
		logic [31:0] v [4];
		logic [31:0] t;
		logic [31:0] key;
		face_word_t  w;
		case (code)
			CODE_EDGE: begin faces = 2; per_face = 1; end
			CODE_TRI:  begin faces = 3; per_face = 2; end
			CODE_QUAD: begin faces = 4; per_face = 2; end
			CODE_TET:  begin faces = 4; per_face = 3; end
			CODE_HEX:  begin faces = 6; per_face = 4; end
			default:   begin faces = 0; per_face = 0; end
		endcase
		if (faces == 0) begin
			w = '{index: 3'd0, key: 32'd0, known: 1'b0, last: 1'b1};
			expected_faces.push_back(w);
		end else begin
			for (int f = 0; f < faces; f++) begin
				for (int k = 0; k < per_face; k++)
					v[k] = nodes[face_slot_node(code, f * per_face + k)];
				// insertion sort, ascending
				for (int k = 1; k < per_face; k++) begin
					t = v[k];
					j = k;
					while (j > 0 && v[j - 1] > t) begin
						v[j] = v[j - 1];
						j--;
					end
					v[j] = t;
				end
				key = v[0];
				for (int k = 1; k < per_face; k++)
					key = cantor_step(key, v[k]);
				w = '{index: 3'(f), key: key, known: 1'b1, last: (f + 1 == faces)};
				expected_faces.push_back(w);
			end
		end
	endtask

	always @(posedge clk) begin : watch
		face_word_t w;
		if (!arst_n) begin
			errors = 0;
			expected_faces.delete();
		end else begin
			if (cell_valid && !cell_stall)
				predict_faces(cell_type, {node_7, node_6, node_5, node_4,
					node_3, node_2, node_1, node_0});
			if (face_valid && !face_stall) begin
				if (expected_faces.size() == 0) begin
					if (errors < 10)
						$display("unexpected face word: idx %0d key %h known %b last %b",
							face_index, face_key, type_known, last_face);
					errors++;
				end else begin
					w = expected_faces.pop_front();
					if (face_index !== w.index || face_key !== w.key ||
							type_known !== w.known || last_face !== w.last) begin
						if (errors < 10)
							$display({"face word mismatch: expected idx %0d key %h ",
								"known %b last %b, got idx %0d key %h known %b last %b"},
								w.index, w.key, w.known, w.last,
								face_index, face_key, type_known, last_face);
						errors++;
					end
				end
			end
		end
		fail_count  <= errors;
		outstanding <= expected_faces.size();
	end

endmodule

[test/mesh_face_key_generator_tb.sv]
// Top of the face key generator testbench: clock, reset, cell word stimulus, face stall and
// the verdict. Needs mfkg_pkg, the block and mfkg_face_checker.
module mesh_face_key_generator_tb
	import mfkg_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        cell_valid = 1'b0;
	logic        cell_stall;
	logic [7:0]  cell_type  = '0;
	logic [31:0] node_0     = '0;
	logic [31:0] node_1     = '0;
	logic [31:0] node_2     = '0;
	logic [31:0] node_3     = '0;
	logic [31:0] node_4     = '0;
	logic [31:0] node_5     = '0;
	logic [31:0] node_6     = '0;
	logic [31:0] node_7     = '0;
	logic        face_valid;
	logic        face_stall = 1'b0;
	logic [2:0]  face_index;
	logic [31:0] face_key;
	logic        type_known;
	logic        last_face;

	int fail_count;
	int outstanding;
	bit gaps_on = 1'b1;	// cleared for the stretch with no idling on either side

	logic [7:0][31:0] nv;
	logic [7:0]       code;

	mesh_face_key_generator u_dut (.*);
	mfkg_face_checker       u_check (.*);

	always #2ns clk = ~clk;

	// receiver: while gaps are on, holds off face words at random, about 23 times in a hundred
	always @(negedge clk)
		face_stall <= gaps_on && ($urandom_range(99) < 23);

	// hard stop, well beyond the slowest legal run (hexahedra with heavy stalling)
	initial begin
		#2ms;
		$display("mesh_face_key_generator test failed");
		$finish;
	end

	// Present one cell word. Random idle cycles go in front of it; once raised, valid and
	// payload hold until the word is taken at a rising edge with stall low.
	task automatic send_cell(logic [7:0] ct, logic [7:0][31:0] nodes);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 23) begin
			cell_valid <= 1'b0;
			@(negedge clk);
		end
		cell_type  <= ct;
		node_0     <= nodes[0];
		node_1     <= nodes[1];
		node_2     <= nodes[2];
		node_3     <= nodes[3];
		node_4     <= nodes[4];
		node_5     <= nodes[5];
		node_6     <= nodes[6];
		node_7     <= nodes[7];
		cell_valid <= 1'b1;
		do @(posedge clk); while (cell_stall !== 1'b0);
	endtask

	// Drop valid and hold off until every predicted face word has come out.
	// Starts on a falling edge so the checker's count already includes the last cell.
	task automatic drain_faces();
		@(negedge clk);
		cell_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	// Mix of full-range, tiny (forces ties in the sort) and near-maximum node numbers.
	function automatic logic [31:0] pick_node();
		logic [31:0] r;
		case ($urandom_range(3))
			0: r = $urandom_range(15);
			1: r = 32'hFFFF_FFFF - $urandom_range(15);
			default: r = $urandom;
		endcase
		return r;
	endfunction

	initial begin
		// reset held low from time zero, released on a falling edge
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// ---- directed cells ----
		// zero and all-ones nodes for every known shape, all-ones only for the quad: the fold wraps hard on all-ones
		send_cell(CODE_EDGE, {8{32'h0}});
		send_cell(CODE_EDGE, {{6{32'h0}}, 32'h0, 32'hFFFF_FFFF});
		send_cell(CODE_TRI,  {{5{32'h0}}, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF});
		send_cell(CODE_QUAD, {8{32'hFFFF_FFFF}});
		send_cell(CODE_TET,  {8{32'h0}});
		send_cell(CODE_TET,  {8{32'hFFFF_FFFF}});
		send_cell(CODE_HEX,  {8{32'h0}});
		send_cell(CODE_HEX,  {8{32'hFFFF_FFFF}});
		// ascending and descending node order, so the sort has work both ways
		for (int i = 0; i < 8; i++) nv[i] = 32'(i);
		send_cell(CODE_HEX, nv);
		send_cell(CODE_QUAD, nv);
		for (int i = 0; i < 8; i++) nv[i] = 32'hFFFF_FFFF - 32'(i);
		send_cell(CODE_HEX, nv);
		send_cell(CODE_TET, nv);
		send_cell(CODE_TRI, nv);
		// alternating extremes and repeated nodes
		send_cell(CODE_HEX, {4{32'h0, 32'hFFFF_FFFF}});
		send_cell(CODE_HEX, {32'd5, 32'd5, 32'd9, 32'd9, 32'd5, 32'd9, 32'd5, 32'd5});
		for (int i = 0; i < 8; i++) nv[i] = $urandom;
		send_cell(CODE_TET, nv);
		send_cell(CODE_EDGE, nv);
		// unknown type codes: the bottom and top of the range and the neighbours of real codes
		send_cell(8'd0,   nv);
		send_cell(8'd255, {8{32'hFFFF_FFFF}});
		send_cell(8'd4,   nv);
		send_cell(8'd11,  nv);
		send_cell(8'd13,  {8{32'h0}});

		// let the block run dry before the random part
		drain_faces();

		// ---- random cells ----
		for (int n = 0; n < 400; n++) begin
			if (n == 120) gaps_on = 1'b0;
			if (n == 220) gaps_on = 1'b1;
			if (n == 300) drain_faces();
			if ($urandom_range(99) < 85) begin
				case ($urandom_range(4))
					0: code = CODE_EDGE;
					1: code = CODE_TRI;
					2: code = CODE_QUAD;
					3: code = CODE_TET;
					default: code = CODE_HEX;
				endcase
			end else begin
				code = 8'($urandom_range(255));
			end
			for (int i = 0; i < 8; i++) nv[i] = pick_node();
			send_cell(code, nv);
		end

		// ---- wind down ----
		drain_faces();
		repeat (100) @(posedge clk);	// room for any stray face word after the last one
		if (fail_count == 0)
			$display("mesh_face_key_generator test passed");
		else
			$display("mesh_face_key_generator test failed");
		$finish;
	end

endmodule
